[src/mswd_pkg.sv]
// Package for the multicore stall watchdog: payload word types, command codes,
// configuration register indexes, reset values and shared control structs.
// No dependencies.
package mswd_pkg;

  // Default build of the block.
  localparam int NUM_CPUS_DEF  = 4;
  localparam int TIME_BITS_DEF = 16;

  // Fixed field widths of the channel words and the configuration port.
  localparam int CMD_W   = 3;
  localparam int CPUIX_W = 2;
  localparam int MASK_W  = 4;
  localparam int THR_W   = 16;
  localparam int WORST_W = 16;
  localparam int CFGIX_W = 2;

  // Command codes of the input word.
  localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SOFT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_HARD = 3'd2;
  localparam logic [CMD_W-1:0] CMD_IRQ  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP = 3'd4;

  // Configuration register indexes.
  localparam logic [CFGIX_W-1:0] CFG_BIND_THR  = 2'd0;
  localparam logic [CFGIX_W-1:0] CFG_STALL_THR = 2'd1;
  localparam logic [CFGIX_W-1:0] CFG_IRQ_PRES  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [THR_W-1:0] BIND_THR_RST  = 16'd24000;
  localparam logic [THR_W-1:0] STALL_THR_RST = 16'd25500;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [CPUIX_W-1:0] cpu_index;
  } in_word_t;

  typedef struct packed {
    logic               restart_pulse;
    logic               bind_request;
    logic [CPUIX_W-1:0] bind_cpu;
    logic               stall_report;
    logic [MASK_W-1:0]  soft_stalled_mask;
    logic [MASK_W-1:0]  hard_stalled_mask;
    logic [WORST_W-1:0] worst_stall_ms;
    logic               stopped;
  } out_word_t;

  // Control of the beat time bank from the sequencer.
  typedef struct packed {
    logic clear_all;
    logic wr_soft;
    logic wr_hard;
    logic rd_hard;
  } bank_ctl_t;

endpackage

[src/mswd_span_unit.sv]
// Shared span unit: clamped subtraction of a beat time from a reference time
// and a compare of the span against a threshold. Depends on mswd_pkg.
module mswd_span_unit #(
  parameter int TIME_BITS = mswd_pkg::TIME_BITS_DEF
) (
  input  logic [TIME_BITS-1:0]          minuend,
  input  logic [TIME_BITS-1:0]          subtrahend,
  input  logic [mswd_pkg::THR_W-1:0]    thr,
  output logic [TIME_BITS-1:0]          span,
  output logic                          at_limit
);

  // A time later than the reference gives a span of zero.
  assign span     = (subtrahend > minuend) ? '0 : (minuend - subtrahend);
  assign at_limit = 32'(span) >= 32'(thr);

endmodule

[src/mswd_time_bank.sv]
// Bank of soft and hard beat times, one of each per CPU, with a single
// clear of every entry and one read port. Depends on mswd_pkg.
module mswd_time_bank #(
  parameter int NUM_CPUS  = mswd_pkg::NUM_CPUS_DEF,
  parameter int TIME_BITS = mswd_pkg::TIME_BITS_DEF,
  parameter int CPU_W     = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mswd_pkg::bank_ctl_t ctl,
  input  logic [CPU_W-1:0]    wr_idx,
  input  logic [TIME_BITS-1:0] wr_data,
  input  logic [CPU_W-1:0]    rd_idx,
  output logic [TIME_BITS-1:0] rd_data
);

  logic [TIME_BITS-1:0] soft_time_r [NUM_CPUS];
  logic [TIME_BITS-1:0] hard_time_r [NUM_CPUS];

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear_all) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        soft_time_r[i] <= '0;
        hard_time_r[i] <= '0;
      end
    end else begin
      if (ctl.wr_soft) begin
        soft_time_r[wr_idx] <= wr_data;
      end
      if (ctl.wr_hard) begin
        hard_time_r[wr_idx] <= wr_data;
      end
    end
  end

  assign rd_data = ctl.rd_hard ? hard_time_r[rd_idx] : soft_time_r[rd_idx];

endmodule

[src/multicore_stall_watchdog_unit.sv]
// Top level of the multicore stall watchdog: command sequencer, configuration
// registers and result register. Depends on mswd_pkg, mswd_span_unit and
// mswd_time_bank.
//
// Use: each input word carries a command (millisecond tick, soft beat, hard
// beat, watchdog interrupt or stop) and the CPU that sent a beat. Every word
// gives exactly one result word on the output channel. Both channels use
// valid and stall; a word moves when valid is high and stall is low.
// Configuration (bind threshold, stall threshold, interrupt present) is to be
// written through the cfg_ port while the block is idle; the block does not enforce it.
// Ticks, soft beats, stops and unused commands go from acceptance straight to
// the done state, which loads the output register. A processed hard beat or a
// watchdog interrupt passes through the walk, bind, check and done states,
// because the one shared span unit visits every soft and hard beat time in
// turn and then checks the bind and stall thresholds. The input is stalled
// until the sequencer is idle again, so no new word is taken before then.
// The result sits in an output register: when the receiver stalls, the word
// holds there and the block still takes the next input word; that word's
// result waits in the sequencer until the register is free.
// Reset (synchronous, active low) clears the time counter, all beat times,
// the alive mask and the halted flag, leaves the interrupt without an owner
// and loads the threshold defaults of 24000 and 25500 ms with no interrupt.
module multicore_stall_watchdog_unit #(
  parameter int NUM_CPUS  = mswd_pkg::NUM_CPUS_DEF,
  parameter int TIME_BITS = mswd_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  mswd_pkg::in_word_t           in_word,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output mswd_pkg::out_word_t          out_word,
  // Configuration write port.
  input  logic                         cfg_we,
  input  logic [mswd_pkg::CFGIX_W-1:0] cfg_index,
  input  logic [mswd_pkg::THR_W-1:0]   cfg_wdata
);

  localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int OWN_W = $clog2(NUM_CPUS + 1);
  localparam logic [CPU_W-1:0] LAST_IDX = CPU_W'(NUM_CPUS - 1);
  localparam logic [TIME_BITS-1:0] TIME_TOP = '1;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_BIND = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // Configuration registers.
  logic [mswd_pkg::THR_W-1:0] bind_thr_r;
  logic [mswd_pkg::THR_W-1:0] stall_thr_r;
  logic                       irq_pres_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bind_thr_r  <= mswd_pkg::BIND_THR_RST;
      stall_thr_r <= mswd_pkg::STALL_THR_RST;
      irq_pres_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        mswd_pkg::CFG_BIND_THR:  bind_thr_r  <= cfg_wdata;
        mswd_pkg::CFG_STALL_THR: stall_thr_r <= cfg_wdata;
        mswd_pkg::CFG_IRQ_PRES:  irq_pres_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Supervision state and sequencer registers.
  logic [2:0]                   state_r, state_nxt;
  logic [TIME_BITS-1:0]         now_r, now_nxt;
  logic [NUM_CPUS-1:0]          alive_r, alive_nxt;
  logic                         halted_r, halted_nxt;
  logic [OWN_W-1:0]             owner_r, owner_nxt;
  logic                         irq_cmd_r, irq_cmd_nxt;
  logic [mswd_pkg::CPUIX_W-1:0] cpu_r, cpu_nxt;
  logic [CPU_W-1:0]             cnt_r, cnt_nxt;
  logic                         sel_hard_r, sel_hard_nxt;
  logic [TIME_BITS-1:0]         max_span_r, max_span_nxt;
  logic [mswd_pkg::MASK_W-1:0]  soft_mask_r, soft_mask_nxt;
  logic [mswd_pkg::MASK_W-1:0]  hard_mask_r, hard_mask_nxt;
  mswd_pkg::out_word_t          res_r, res_nxt;
  logic                         out_valid_r, out_valid_nxt;
  mswd_pkg::out_word_t          out_word_r, out_word_nxt;

  // Datapath connections.
  mswd_pkg::bank_ctl_t        bank_ctl;
  logic [TIME_BITS-1:0]       bank_rd_data;
  logic [TIME_BITS-1:0]       unit_a;
  logic [TIME_BITS-1:0]       unit_b;
  logic [mswd_pkg::THR_W-1:0] unit_thr;
  logic [TIME_BITS-1:0]       unit_span;
  logic                       unit_at_limit;

  logic                       in_accept;
  logic                       cpu_ok;
  logic [CPU_W-1:0]           in_cpu_idx;
  logic [NUM_CPUS-1:0]        alive_set;
  logic [4:0]                 cnt_ext;
  logic [31:0]                span_wide;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign cpu_ok     = 5'(in_word.cpu_index) < 5'(NUM_CPUS);
  assign in_cpu_idx = CPU_W'(in_word.cpu_index);
  assign alive_set  = alive_r | (NUM_CPUS'(1) << in_cpu_idx);
  assign cnt_ext    = 5'(cnt_r);
  assign span_wide  = 32'(max_span_r);

  mswd_time_bank #(
    .NUM_CPUS  (NUM_CPUS),
    .TIME_BITS (TIME_BITS),
    .CPU_W     (CPU_W)
  ) u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (bank_ctl),
    .wr_idx  (in_cpu_idx),
    .wr_data (now_r),
    .rd_idx  (cnt_r),
    .rd_data (bank_rd_data)
  );

  // During the walk the unit measures each beat time against now; in the two
  // check steps it compares the largest soft span with a threshold. The
  // largest soft span is the span from the oldest soft beat.
  assign unit_a   = (state_r == ST_WALK) ? now_r : max_span_r;
  assign unit_b   = (state_r == ST_WALK) ? bank_rd_data : '0;
  assign unit_thr = (state_r == ST_BIND) ? bind_thr_r : stall_thr_r;

  mswd_span_unit #(
    .TIME_BITS (TIME_BITS)
  ) u_span (
    .minuend    (unit_a),
    .subtrahend (unit_b),
    .thr        (unit_thr),
    .span       (unit_span),
    .at_limit   (unit_at_limit)
  );

  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    alive_nxt     = alive_r;
    halted_nxt    = halted_r;
    owner_nxt     = owner_r;
    irq_cmd_nxt   = irq_cmd_r;
    cpu_nxt       = cpu_r;
    cnt_nxt       = cnt_r;
    sel_hard_nxt  = sel_hard_r;
    max_span_nxt  = max_span_r;
    soft_mask_nxt = soft_mask_r;
    hard_mask_nxt = hard_mask_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    bank_ctl      = '0;
    bank_ctl.rd_hard = sel_hard_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          res_nxt       = '0;
          cpu_nxt       = in_word.cpu_index;
          irq_cmd_nxt   = 1'b0;
          cnt_nxt       = '0;
          sel_hard_nxt  = 1'b0;
          max_span_nxt  = '0;
          soft_mask_nxt = '0;
          hard_mask_nxt = '0;
          state_nxt     = ST_DONE;
          case (in_word.cmd)
            mswd_pkg::CMD_TICK: begin
              if (now_r != TIME_TOP) begin
                now_nxt = now_r + 1'b1;
              end
            end
            mswd_pkg::CMD_SOFT: begin
              if (!halted_r && cpu_ok) begin
                if (&alive_set) begin
                  // Every CPU has checked in: kick and start a new round.
                  alive_nxt          = '0;
                  now_nxt            = '0;
                  bank_ctl.clear_all = 1'b1;
                  res_nxt.restart_pulse = 1'b1;
                end else begin
                  alive_nxt        = alive_set;
                  bank_ctl.wr_soft = 1'b1;
                end
              end
            end
            mswd_pkg::CMD_HARD: begin
              if (!halted_r && cpu_ok) begin
                bank_ctl.wr_hard = 1'b1;
                state_nxt        = ST_WALK;
              end
            end
            mswd_pkg::CMD_IRQ: begin
              irq_cmd_nxt = 1'b1;
              state_nxt   = ST_WALK;
            end
            mswd_pkg::CMD_STOP: begin
              res_nxt.restart_pulse = 1'b1;
              now_nxt    = '0;
              halted_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end

      ST_WALK: begin
        if (!sel_hard_r) begin
          if (unit_span > max_span_r) begin
            max_span_nxt = unit_span;
          end
          if (cnt_ext < 5'(mswd_pkg::MASK_W)) begin
            soft_mask_nxt[cnt_ext[1:0]] = unit_at_limit;
          end
          sel_hard_nxt = 1'b1;
        end else begin
          if (cnt_ext < 5'(mswd_pkg::MASK_W)) begin
            hard_mask_nxt[cnt_ext[1:0]] = unit_at_limit;
          end
          sel_hard_nxt = 1'b0;
          if (cnt_r == LAST_IDX) begin
            state_nxt = ST_BIND;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end

      ST_BIND: begin
        // The worst span saturates at the width of the result field.
        res_nxt.worst_stall_ms = (span_wide > 32'hFFFF) ? '1 : span_wide[15:0];
        if (!irq_cmd_r && unit_at_limit && irq_pres_r &&
            owner_r != OWN_W'(cpu_r)) begin
          owner_nxt            = OWN_W'(cpu_r);
          res_nxt.bind_request = 1'b1;
          res_nxt.bind_cpu     = cpu_r;
        end
        state_nxt = ST_CHK;
      end

      ST_CHK: begin
        if (irq_cmd_r || (!irq_pres_r && unit_at_limit)) begin
          halted_nxt                = 1'b1;
          res_nxt.stall_report      = 1'b1;
          res_nxt.soft_stalled_mask = soft_mask_r;
          res_nxt.hard_stalled_mask = hard_mask_r;
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_word_nxt         = res_r;
          out_word_nxt.stopped = halted_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      alive_r     <= '0;
      halted_r    <= 1'b0;
      owner_r     <= OWN_W'(NUM_CPUS);
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      sel_hard_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      alive_r     <= alive_nxt;
      halted_r    <= halted_nxt;
      owner_r     <= owner_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      sel_hard_r  <= sel_hard_nxt;
    end
  end

  always_ff @(posedge clk) begin
    irq_cmd_r   <= irq_cmd_nxt;
    cpu_r       <= cpu_nxt;
    max_span_r  <= max_span_nxt;
    soft_mask_r <= soft_mask_nxt;
    hard_mask_r <= hard_mask_nxt;
    res_r       <= res_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
